@@ sv/agu_pkg.sv @@
// shared types and constants of the activation gradient unit
package agu_pkg;

    localparam int DATA_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 12;
    localparam int QUEUE_DEPTH_DEF = 4;
    // back pipeline stages up to and including the output register
    localparam int BACK_STAGES     = 11;

    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_SILU    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_GELU    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TANH    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SIGMOID = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SOFTMAX = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RELU    = 3'd5;

    // one-hot operation class decoded from the command
    typedef struct packed {
        logic m_silu;
        logic m_gelu;
        logic m_tanh;
        logic m_sig;
        logic m_smax;
        logic m_relu;
        logic m_none;
    } agu_kind_t;

    localparam int KIND_W = $bits(agu_kind_t);

endpackage

@@ sv/agu_front.sv @@
// front part: takes input words and classifies the command
module agu_front #(
    parameter int DATA_WIDTH = agu_pkg::DATA_WIDTH_DEF
) (
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [agu_pkg::CMD_W-1:0]    cmd,
    input  logic signed [DATA_WIDTH-1:0] x_value,
    input  logic signed [DATA_WIDTH-1:0] grad_value,
    input  logic                         q_full,
    output logic                         q_push,
    output agu_pkg::agu_kind_t           q_kind,
    output logic signed [DATA_WIDTH-1:0] q_x,
    output logic signed [DATA_WIDTH-1:0] q_g
);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_x      = x_value;
    assign q_g      = grad_value;

    always_comb
    begin
        q_kind = '0;
        case (cmd)
            agu_pkg::CMD_SILU:    q_kind.m_silu = 1'b1;
            agu_pkg::CMD_GELU:    q_kind.m_gelu = 1'b1;
            agu_pkg::CMD_TANH:    q_kind.m_tanh = 1'b1;
            agu_pkg::CMD_SIGMOID: q_kind.m_sig  = 1'b1;
            agu_pkg::CMD_SOFTMAX: q_kind.m_smax = 1'b1;
            agu_pkg::CMD_RELU:    q_kind.m_relu = 1'b1;
            default:              q_kind.m_none = 1'b1;
        endcase
    end

endmodule

@@ sv/agu_queue.sv @@
// short queue between the front and back parts
module agu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = agu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ sv/agu_back.sv @@
// back part: derivative pipeline and output register
module agu_back #(
    parameter int DATA_WIDTH = agu_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = agu_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  agu_pkg::agu_kind_t           q_kind,
    input  logic signed [DATA_WIDTH-1:0] q_x,
    input  logic signed [DATA_WIDTH-1:0] q_g,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] grad_out,
    output logic                         saturated
);

    localparam int DW = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int LW = 2 * DW + F + 4;
    // multiplier operand width, enough for the capped factor
    localparam int MW = DW + F + 1;
    localparam int NS = agu_pkg::BACK_STAGES - 1;

    localparam logic signed [LW-1:0] ONE   = LW'(1) <<< F;
    localparam logic signed [LW-1:0] HALF  = LW'(1) <<< (F - 1);
    localparam logic [LW-1:0] C_5      = LW'(5) << F;
    localparam logic [LW-1:0] C_19     = (LW'(19) << F) >> 3;
    localparam logic [LW-1:0] C_27     = (LW'(27) << F) >> 5;
    localparam logic [LW-1:0] C_5_8    = (LW'(5) << F) >> 3;
    localparam logic [LW-1:0] C_ONE    = LW'(1) << F;
    localparam logic [LW-1:0] C_HALF   = LW'(1) << (F - 1);
    localparam logic signed [LW-1:0] K0 =
        LW'((64'sd856722066 + (64'sd1 <<< (29 - F))) >>> (30 - F));
    localparam logic signed [LW-1:0] K1 =
        LW'((64'sd48012366 + (64'sd1 <<< (29 - F))) >>> (30 - F));
    localparam logic signed [LW-1:0] K3 =
        LW'((64'sd144037097 + (64'sd1 <<< (29 - F))) >>> (30 - F));
    localparam logic signed [LW-1:0] GELU_LIM = LW'(4) <<< F;
    localparam logic signed [LW-1:0] F_CAP    = LW'(1) <<< (DW + F);
    localparam logic signed [LW-1:0] D_MAX    = LW'((64'sd1 <<< (DW - 1)) - 1);
    localparam logic signed [LW-1:0] D_MIN    = -(LW'(1) <<< (DW - 1));

    // rounded fixed point product, round half away from zero
    // operand magnitudes stay within MW bits on every path
    function automatic logic signed [LW-1:0] qmul(input logic signed [LW-1:0] a,
                                                  input logic signed [LW-1:0] b);
        logic [LW-1:0]   ua;
        logic [LW-1:0]   ub;
        logic [2*MW-1:0] p;
        logic [LW-1:0]   m;
        ua = a[LW-1] ? LW'(-a) : LW'(a);
        ub = b[LW-1] ? LW'(-b) : LW'(b);
        p  = {{MW{1'b0}}, ua[MW-1:0]} * {{MW{1'b0}}, ub[MW-1:0]};
        p  = p + ((2*MW)'(1) << (F - 1));
        m  = LW'(p >> F);
        return (a[LW-1] ^ b[LW-1]) ? -$signed(m) : $signed(m);
    endfunction

    // piecewise linear sigmoid
    function automatic logic signed [LW-1:0] sig_f(input logic signed [LW-1:0] v);
        logic [LW-1:0] m;
        logic [LW-1:0] s;
        m = v[LW-1] ? LW'(-v) : LW'(v);
        if (m >= C_5)
            s = C_ONE;
        else if (m >= C_19)
            s = (m >> 5) + C_27;
        else if (m >= C_ONE)
            s = (m >> 3) + C_5_8;
        else
            s = (m >> 2) + C_HALF;
        return v[LW-1] ? ONE - $signed(s) : $signed(s);
    endfunction

    function automatic logic signed [LW-1:0] th_f(input logic signed [LW-1:0] v);
        return (sig_f(v <<< 1) <<< 1) - ONE;
    endfunction

    logic                    adv;
    logic [NS:1]             vld_reg;
    agu_pkg::agu_kind_t      kind_reg [1:NS];
    logic signed [LW-1:0]    x_reg    [1:NS];
    logic signed [DW-1:0]    g_reg    [1:NS];

    logic signed [LW-1:0] a1_reg, x2_1_reg;
    logic signed [LW-1:0] a2_reg, p2_reg, kx2_reg;
    logic signed [LW-1:0] a3_reg, p3_reg, b3_reg, igp3_reg;
    logic signed [LW-1:0] c4_reg, ig4_reg;
    logic signed [LW-1:0] c5_reg, ig5_reg;
    logic signed [LW-1:0] c6_reg, t6_reg, ig6_reg;
    logic signed [LW-1:0] c7_reg, tt7_reg, hx7_reg, h17_reg, ig7_reg;
    logic signed [LW-1:0] c8_reg, si8_reg, hx8_reg, h18_reg;
    logic signed [LW-1:0] f9_reg;
    logic signed [LW-1:0] r10_reg;
    logic signed [DW-1:0] grad_out_reg;
    logic                 sat_reg;
    logic                 out_valid_reg;

    logic signed [LW-1:0] xin;
    logic signed [LW-1:0] sg1_next, a1_next;
    logic signed [LW-1:0] p2_next, mo2;
    logic signed [LW-1:0] c4_next;
    logic signed [LW-1:0] fg9, f9_next;
    logic signed [LW-1:0] fc10;
    logic signed [DW-1:0] grad_out_next;
    logic                 sat_next;

    assign adv       = !out_valid_reg || out_ready;
    assign q_pop     = adv && !q_empty;
    assign out_valid = out_valid_reg;
    assign grad_out  = grad_out_reg;
    assign saturated = sat_reg;

    assign xin = LW'(q_x);

    // stage 1: sigmoid or tanh of x, and x squared
    always_comb
    begin
        sg1_next = sig_f(q_kind.m_tanh ? (xin <<< 1) : xin);
        a1_next  = q_kind.m_tanh ? ((sg1_next <<< 1) - ONE) : sg1_next;
    end

    // stage 2: the main product of each mode
    always_comb
    begin
        mo2 = x2_1_reg;
        if (kind_reg[1].m_gelu)
            p2_next = qmul(x2_1_reg, x_reg[1]);
        else if (kind_reg[1].m_tanh)
            p2_next = qmul(a1_reg, a1_reg);
        else if (kind_reg[1].m_smax)
            p2_next = qmul(x_reg[1], ONE - x_reg[1]);
        else
            p2_next = qmul(a1_reg, ONE - a1_reg);
    end

    // stage 4: factor of the plain modes, or gelu inner sum
    always_comb
    begin
        if (kind_reg[3].m_silu)
            c4_next = a3_reg + b3_reg;
        else if (kind_reg[3].m_tanh)
            c4_next = ONE - p3_reg;
        else if (kind_reg[3].m_gelu)
            c4_next = x_reg[3] + b3_reg;
        else
            c4_next = p3_reg;
    end

    // stage 9: gelu closing sum and large-input override
    always_comb
    begin
        fg9 = h18_reg + qmul(hx8_reg, si8_reg);
        if (!kind_reg[8].m_gelu)
            f9_next = c8_reg;
        else if (x_reg[8] >= GELU_LIM)
            f9_next = ONE;
        else if (x_reg[8] <= -GELU_LIM)
            f9_next = '0;
        else
            f9_next = fg9;
    end

    // stage 10: cap factor so the product stays in range, then scale by g
    always_comb
    begin
        if (f9_reg > F_CAP)
            fc10 = F_CAP;
        else if (f9_reg < -F_CAP)
            fc10 = -F_CAP;
        else
            fc10 = f9_reg;
    end

    // output stage: saturate, relu mask, unused modes
    always_comb
    begin
        grad_out_next = '0;
        sat_next      = 1'b0;
        if (kind_reg[10].m_relu)
        begin
            grad_out_next = (x_reg[10] > 0) ? g_reg[10] : '0;
        end
        else if (!kind_reg[10].m_none)
        begin
            if (r10_reg > D_MAX)
            begin
                grad_out_next = DW'(D_MAX);
                sat_next      = 1'b1;
            end
            else if (r10_reg < D_MIN)
            begin
                grad_out_next = DW'(D_MIN);
                sat_next      = 1'b1;
            end
            else
            begin
                grad_out_next = DW'(r10_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[NS-1:1], q_pop};
            out_valid_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg[1] <= q_kind;
            x_reg[1]    <= xin;
            g_reg[1]    <= q_g;
            for (int i = 2; i <= NS; i++)
            begin
                kind_reg[i] <= kind_reg[i-1];
                x_reg[i]    <= x_reg[i-1];
                g_reg[i]    <= g_reg[i-1];
            end

            a1_reg   <= a1_next;
            x2_1_reg <= qmul(xin, xin);

            a2_reg  <= a1_reg;
            p2_reg  <= p2_next;
            kx2_reg <= qmul(K3, mo2);

            a3_reg   <= a2_reg;
            p3_reg   <= p2_reg;
            b3_reg   <= kind_reg[2].m_gelu ? qmul(K1, p2_reg) : qmul(x_reg[2], p2_reg);
            igp3_reg <= ONE + kx2_reg;

            c4_reg  <= c4_next;
            ig4_reg <= qmul(K0, igp3_reg);

            c5_reg  <= kind_reg[4].m_gelu ? qmul(K0, c4_reg) : c4_reg;
            ig5_reg <= ig4_reg;

            c6_reg  <= c5_reg;
            t6_reg  <= th_f(c5_reg);
            ig6_reg <= ig5_reg;

            c7_reg  <= c6_reg;
            tt7_reg <= qmul(t6_reg, t6_reg);
            hx7_reg <= qmul(HALF, x_reg[6]);
            h17_reg <= qmul(HALF, ONE + t6_reg);
            ig7_reg <= ig6_reg;

            c8_reg  <= c7_reg;
            si8_reg <= qmul(ONE - tt7_reg, ig7_reg);
            hx8_reg <= hx7_reg;
            h18_reg <= h17_reg;

            f9_reg  <= f9_next;
            r10_reg <= qmul(fc10, LW'(g_reg[9]));

            grad_out_reg <= grad_out_next;
            sat_reg      <= sat_next;
        end
    end

endmodule

@@ sv/activation_gradient_unit.sv @@
// top level of the activation gradient unit
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  in      | in_valid / in_ready  | cmd, x_value, grad_value
//  out     | out_valid / out_ready| grad_out, saturated
//
// one word per cycle sustained while out_ready holds; each word passes the queue
// and then the derivative pipeline before out_valid
// in_ready drops only when the queue is full, so it takes up to QUEUE_DEPTH
// more words after the output stalls
// a stall on out freezes the whole back pipeline; the front keeps filling
// the queue
// rst_n clears queue pointers and pipeline valid bits, no clearing pass
module activation_gradient_unit #(
    parameter int DATA_WIDTH  = agu_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS   = agu_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = agu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [agu_pkg::CMD_W-1:0]    cmd,
    input  logic signed [DATA_WIDTH-1:0] x_value,
    input  logic signed [DATA_WIDTH-1:0] grad_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] grad_out,
    output logic                         saturated
);

    // queue word: decoded class, forward value, upstream gradient
    localparam int QW = agu_pkg::KIND_W + 2 * DATA_WIDTH;

    logic                         q_full;
    logic                         q_empty;
    logic                         q_push;
    logic                         q_pop;
    agu_pkg::agu_kind_t           f_kind;
    logic signed [DATA_WIDTH-1:0] f_x;
    logic signed [DATA_WIDTH-1:0] f_g;
    logic [QW-1:0]                q_rd;
    agu_pkg::agu_kind_t           b_kind;
    logic signed [DATA_WIDTH-1:0] b_x;
    logic signed [DATA_WIDTH-1:0] b_g;

    agu_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .x_value    (x_value),
        .grad_value (grad_value),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_kind     (f_kind),
        .q_x        (f_x),
        .q_g        (f_g)
    );

    agu_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_kind, f_x, f_g}),
        .pop       (q_pop),
        .pop_data  (q_rd),
        .full      (q_full),
        .empty     (q_empty)
    );

    // unpack the queue word
    assign b_kind = q_rd[QW-1 -: agu_pkg::KIND_W];
    assign b_x    = q_rd[2*DATA_WIDTH-1 -: DATA_WIDTH];
    assign b_g    = q_rd[DATA_WIDTH-1:0];

    agu_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_kind    (b_kind),
        .q_x       (b_x),
        .q_g       (b_g),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .grad_out  (grad_out),
        .saturated (saturated)
    );

endmodule

@@ sv/agu_checker.sv @@
// port-level checks of the activation gradient unit
module agu_checker #(
    parameter int DATA_WIDTH  = agu_pkg::DATA_WIDTH_DEF,
    parameter int QUEUE_DEPTH = agu_pkg::QUEUE_DEPTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [DATA_WIDTH-1:0] grad_out,
    input logic                         saturated
);

    localparam int CAPACITY = QUEUE_DEPTH + agu_pkg::BACK_STAGES;
    localparam int NW       = $clog2(CAPACITY + 2);
    localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [NW-1:0] inflight_reg;
    logic          in_acc;
    logic          out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            inflight_reg <= inflight_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            inflight_reg <= inflight_reg - 1'b1;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(grad_out) && $stable(saturated))
        else $error("result changed while stalled");

    // a clipped result sits at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (grad_out == D_MAX) || (grad_out == D_MIN))
        else $error("saturated result not at a rail");

    // no result without an accepted word behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result without input");

    // never more words held than queue and pipeline can carry
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= NW'(CAPACITY))
        else $error("word count exceeds capacity");

endmodule

bind activation_gradient_unit agu_checker #(
    .DATA_WIDTH  (DATA_WIDTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_agu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .grad_out  (grad_out),
    .saturated (saturated)
);
